>>> rtl/core/lghd_pkg.sv
// Shared widths, register codes, pipeline records and helpers for the
// lidar ground hole detector. No dependencies.
`timescale 1ns / 1ps

package lghd_pkg;

  localparam int unsigned CRD_W    = 20;  // coordinates, plane offset
  localparam int unsigned NRM_W    = 16;  // Q1.15 normal components
  localparam int unsigned NRM_FRAC = 15;
  localparam int unsigned TOL_W    = 16;
  localparam int unsigned DIF_W    = CRD_W + 1;  // point minus origin
  localparam int unsigned DEN_W    = 38;         // den and num, signed
  localparam int unsigned MAG_W    = DEN_W - 1;  // |den|, |num|
  localparam int unsigned R2_W     = 42;         // squared range
  localparam int unsigned RP_W     = 21;         // range of the point
  localparam int unsigned SQ_W     = R2_W + 1;
  localparam int unsigned SQ_STEPS = RP_W;       // one result bit per stage
  localparam int unsigned NUM_LO_W = 19;         // low part of |num|
  localparam int unsigned NUM_HI_W = MAG_W - NUM_LO_W;
  localparam int unsigned PL_W     = NUM_LO_W + RP_W;
  localparam int unsigned PH_W     = NUM_HI_W + RP_W;
  localparam int unsigned PRD_W    = MAG_W + RP_W;
  localparam int unsigned DIV_W    = 62;
  localparam int unsigned QUO_W    = 22;         // quotient clamps at 2^22-1
  localparam int unsigned EXT_W    = QUO_W + 1;
  localparam int unsigned IX_W     = EXT_W + 1;
  localparam int unsigned CMP_W    = IX_W + 1;
  localparam int unsigned LANES    = 4;          // x, y, z, range
  localparam int unsigned LANE_R   = 3;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW  = $clog2(FIFO_DEPTH);
  localparam int unsigned BK_STAGES = (SQ_STEPS + 1) + 2 + (QUO_W + 1);

  localparam int HEIGHT_MARGIN = 100;
  localparam int CRD_MAX = 2 ** (CRD_W - 1) - 1;
  localparam int CRD_MIN = -(2 ** (CRD_W - 1));

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = CRD_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_ORIGIN_Z   = 3'd2,
    REG_NORMAL_A   = 3'd3,
    REG_NORMAL_B   = 3'd4,
    REG_NORMAL_C   = 3'd5,
    REG_PLANE_OFS  = 3'd6,
    REG_RANGE_TOL  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [CRD_W-1:0] ox;
    logic signed [CRD_W-1:0] oy;
    logic signed [CRD_W-1:0] oz;
    logic signed [NRM_W-1:0] a;
    logic signed [NRM_W-1:0] b;
    logic signed [NRM_W-1:0] c;
    logic signed [CRD_W-1:0] d;
    logic [TOL_W-1:0]        tol;
  } cfg_t;

  // one non-parallel point handed from front to back
  typedef struct packed {
    logic signed [CRD_W-1:0] px;
    logic signed [CRD_W-1:0] py;
    logic signed [CRD_W-1:0] pz;
    logic signed [DIF_W-1:0] dx;
    logic signed [DIF_W-1:0] dy;
    logic signed [DIF_W-1:0] dz;
    logic signed [DEN_W-1:0] den;
    logic signed [DEN_W-1:0] num;
    logic [R2_W-1:0]         r2;
  } job_t;

  typedef struct packed {
    job_t            job;
    logic [SQ_W-1:0] v;
    logic [SQ_W-1:0] r;
  } sq_t;

  typedef struct packed {
    logic [LANES-1:0][PL_W-1:0] pl;
    logic [LANES-1:0][PH_W-1:0] ph;
    logic [MAG_W-1:0]           abs_den;
    logic [2:0]                 neg;
    logic signed [CRD_W-1:0]    px;
    logic signed [CRD_W-1:0]    py;
    logic signed [CRD_W-1:0]    pz;
    logic [RP_W-1:0]            rp;
  } mul_t;

  typedef struct packed {
    logic [LANES-1:0][DIV_W-1:0] rem;
    logic [LANES-1:0][QUO_W-1:0] quo;
    logic [LANES-1:0]            ovf;
    logic [DIV_W-1:0]            dvs;
    logic [2:0]                  neg;
    logic signed [CRD_W-1:0]     px;
    logic signed [CRD_W-1:0]     py;
    logic signed [CRD_W-1:0]     pz;
    logic [RP_W-1:0]             rp;
  } div_t;

  function automatic logic [MAG_W-1:0] abs_wide(input logic signed [DEN_W-1:0] v);
    logic signed [DEN_W-1:0] t;
    t = v[DEN_W-1] ? -v : v;
    return t[MAG_W-1:0];
  endfunction

  function automatic logic [DIF_W-1:0] abs_dif(input logic signed [DIF_W-1:0] v);
    return v[DIF_W-1] ? DIF_W'(-v) : DIF_W'(v);
  endfunction

  function automatic logic [CRD_W-1:0] sat_crd(input logic signed [IX_W-1:0] v);
    logic [CRD_W-1:0] r;
    if (v > IX_W'(CRD_MAX)) begin
      r = CRD_W'(CRD_MAX);
    end else if (v < IX_W'(CRD_MIN)) begin
      r = CRD_W'(CRD_MIN);
    end else begin
      r = v[CRD_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/lghd_stream_if.sv
// Valid/ready channels for points in and holes out.
// Depends on lghd_pkg.
`timescale 1ns / 1ps

interface lghd_point_if import lghd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [CRD_W-1:0] point_x;
  logic signed [CRD_W-1:0] point_y;
  logic signed [CRD_W-1:0] point_z;

  modport source(output valid, output point_x, output point_y, output point_z,
                 input ready);
  modport sink(input valid, input point_x, input point_y, input point_z,
               output ready);
endinterface

interface lghd_hole_if import lghd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [CRD_W-1:0] hole_x;
  logic signed [CRD_W-1:0] hole_y;
  logic signed [CRD_W-1:0] hole_z;
  logic signed [CRD_W-1:0] raw_x;
  logic signed [CRD_W-1:0] raw_y;
  logic signed [CRD_W-1:0] raw_z;

  modport source(output valid, output hole_x, output hole_y, output hole_z,
                 output raw_x, output raw_y, output raw_z, input ready);
  modport sink(input valid, input hole_x, input hole_y, input hole_z,
               input raw_x, input raw_y, input raw_z, output ready);
endinterface

>>> rtl/core/lghd_front.sv
// Front end: takes point requests, forms ray offset, plane products, squared
// range; drops parallel rays and pushes the rest. Depends on lghd_pkg.
`timescale 1ns / 1ps

module lghd_front import lghd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  lghd_point_if.sink point_i,
  input  logic       full_i,
  output logic       push_o,
  output job_t       job_o
);

  logic en;
  logic f1_vld_q, f2_vld_q;
  logic signed [CRD_W-1:0] f1_px_q, f1_py_q, f1_pz_q;
  logic signed [DIF_W-1:0] f1_dx_q, f1_dy_q, f1_dz_q;
  logic signed [DIF_W-1:0] dx_d, dy_d, dz_d;

  logic signed [CRD_W-1:0] f2_px_q, f2_py_q, f2_pz_q;
  logic signed [DIF_W-1:0] f2_dx_q, f2_dy_q, f2_dz_q;
  logic signed [DEN_W-1:0] adx_q, bdy_q, cdz_q, aox_q, boy_q, coz_q;
  logic signed [R2_W-1:0]  sx_q, sy_q, sz_q;
  logic signed [DEN_W-1:0] den, num;

  assign en            = !full_i;
  assign point_i.ready = en;

  assign dx_d = DIF_W'(point_i.point_x) - DIF_W'(cfg_i.ox);
  assign dy_d = DIF_W'(point_i.point_y) - DIF_W'(cfg_i.oy);
  assign dz_d = DIF_W'(point_i.point_z) - DIF_W'(cfg_i.oz);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
    end else if (en) begin
      f1_vld_q <= point_i.valid;
      f2_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_px_q <= point_i.point_x;
      f1_py_q <= point_i.point_y;
      f1_pz_q <= point_i.point_z;
      f1_dx_q <= dx_d;
      f1_dy_q <= dy_d;
      f1_dz_q <= dz_d;

      f2_px_q <= f1_px_q;
      f2_py_q <= f1_py_q;
      f2_pz_q <= f1_pz_q;
      f2_dx_q <= f1_dx_q;
      f2_dy_q <= f1_dy_q;
      f2_dz_q <= f1_dz_q;
      adx_q   <= DEN_W'(cfg_i.a) * DEN_W'(f1_dx_q);
      bdy_q   <= DEN_W'(cfg_i.b) * DEN_W'(f1_dy_q);
      cdz_q   <= DEN_W'(cfg_i.c) * DEN_W'(f1_dz_q);
      aox_q   <= DEN_W'(cfg_i.a) * DEN_W'(cfg_i.ox);
      boy_q   <= DEN_W'(cfg_i.b) * DEN_W'(cfg_i.oy);
      coz_q   <= DEN_W'(cfg_i.c) * DEN_W'(cfg_i.oz);
      sx_q    <= R2_W'(f1_dx_q) * R2_W'(f1_dx_q);
      sy_q    <= R2_W'(f1_dy_q) * R2_W'(f1_dy_q);
      sz_q    <= R2_W'(f1_dz_q) * R2_W'(f1_dz_q);
    end
  end

  assign den = adx_q + bdy_q + cdz_q;
  assign num = -(aox_q + boy_q + coz_q + (DEN_W'(cfg_i.d) <<< NRM_FRAC));

  // parallel ray: nothing to intersect, never reaches the back end
  assign push_o = en && f2_vld_q && (den != '0);

  always_comb begin
    job_o.px  = f2_px_q;
    job_o.py  = f2_py_q;
    job_o.pz  = f2_pz_q;
    job_o.dx  = f2_dx_q;
    job_o.dy  = f2_dy_q;
    job_o.dz  = f2_dz_q;
    job_o.den = den;
    job_o.num = num;
    job_o.r2  = R2_W'(sx_q) + R2_W'(sy_q) + R2_W'(sz_q);
  end

endmodule

>>> rtl/core/lghd_fifo.sv
// Short job queue between front and back end.
// Depends on lghd_pkg.
`timescale 1ns / 1ps

module lghd_fifo import lghd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t head_o,
  output logic head_vld_o
);

  job_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_q, rd_q;
  logic [FIFO_AW:0]     cnt_q;

  assign full_o     = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign head_vld_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !head_vld_o))
    else $error("pop from empty queue");

  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count lost a push");

endmodule

>>> rtl/core/lghd_back.sv
// Back end: range square root, products, clamped rounding dividers, ground
// and hole tests, output register. Depends on lghd_pkg, lghd_stream_if.
`timescale 1ns / 1ps

module lghd_back import lghd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  job_t         head_i,
  input  logic         head_vld_i,
  output logic         pop_o,
  lghd_hole_if.source  hole_o
);

  logic                 en;
  logic [BK_STAGES-1:0] vld_q;

  sq_t  sq_q [SQ_STEPS+1];
  sq_t  sq_d [SQ_STEPS+1];
  mul_t m1_q, m1_d;
  div_t m2_q, m2_d;
  div_t dv_q [QUO_W+1];
  div_t dv_d [QUO_W+1];

  logic                    out_vld_q;
  logic [CRD_W-1:0]        hx_q, hy_q, hz_q, rx_q, ry_q, rz_q;
  logic                    hole_d;
  logic [CRD_W-1:0]        hx_d, hy_d, hz_d;

  assign en    = !out_vld_q || hole_o.ready;
  assign pop_o = en && head_vld_i;

  // integer square root, one result bit per stage
  always_comb begin
    logic [SQ_W-1:0] sb, tr;
    sq_d[0].job = head_i;
    sq_d[0].v   = SQ_W'(head_i.r2);
    sq_d[0].r   = '0;
    for (int i = 0; i < SQ_STEPS; i++) begin
      sb = SQ_W'(1) << (2 * (SQ_STEPS - 1 - i));
      tr = sq_q[i].r + sb;
      sq_d[i+1].job = sq_q[i].job;
      if (sq_q[i].v >= tr) begin
        sq_d[i+1].v = sq_q[i].v - tr;
        sq_d[i+1].r = (sq_q[i].r >> 1) + sb;
      end else begin
        sq_d[i+1].v = sq_q[i].v;
        sq_d[i+1].r = sq_q[i].r >> 1;
      end
    end
  end

  // split products |num| * {|dx|, |dy|, |dz|, rp}
  always_comb begin
    job_t             j;
    logic [MAG_W-1:0] an;
    logic [RP_W-1:0]  mb [LANES];
    j     = sq_q[SQ_STEPS].job;
    an    = abs_wide(j.num);
    mb[0] = abs_dif(j.dx);
    mb[1] = abs_dif(j.dy);
    mb[2] = abs_dif(j.dz);
    mb[LANE_R] = sq_q[SQ_STEPS].r[RP_W-1:0];
    for (int k = 0; k < LANES; k++) begin
      m1_d.pl[k] = PL_W'(an[NUM_LO_W-1:0]) * PL_W'(mb[k]);
      m1_d.ph[k] = PH_W'(an[MAG_W-1:NUM_LO_W]) * PH_W'(mb[k]);
    end
    m1_d.abs_den = abs_wide(j.den);
    m1_d.neg[0]  = j.num[DEN_W-1] ^ j.dx[DIF_W-1] ^ j.den[DEN_W-1];
    m1_d.neg[1]  = j.num[DEN_W-1] ^ j.dy[DIF_W-1] ^ j.den[DEN_W-1];
    m1_d.neg[2]  = j.num[DEN_W-1] ^ j.dz[DIF_W-1] ^ j.den[DEN_W-1];
    m1_d.px      = j.px;
    m1_d.py      = j.py;
    m1_d.pz      = j.pz;
    m1_d.rp      = sq_q[SQ_STEPS].r[RP_W-1:0];
  end

  // rounding numerator 2|n| + |den| over divisor 2|den|
  always_comb begin
    logic [PRD_W-1:0] prod;
    m2_d.quo = '0;
    m2_d.ovf = '0;
    for (int k = 0; k < LANES; k++) begin
      prod = (PRD_W'(m1_q.ph[k]) << NUM_LO_W) + PRD_W'(m1_q.pl[k]);
      m2_d.rem[k] = (DIV_W'(prod) << 1) + DIV_W'(m1_q.abs_den);
    end
    m2_d.dvs = DIV_W'(m1_q.abs_den) << 1;
    m2_d.neg = m1_q.neg;
    m2_d.px  = m1_q.px;
    m2_d.py  = m1_q.py;
    m2_d.pz  = m1_q.pz;
    m2_d.rp  = m1_q.rp;
  end

  // dividers: a quotient too large for QUO_W bits clamps; it saturates anyway
  always_comb begin
    logic [DIV_W-1:0] sh;
    dv_d[0] = m2_q;
    for (int k = 0; k < LANES; k++) begin
      dv_d[0].ovf[k] = (m2_q.rem[k] >= (m2_q.dvs << QUO_W));
    end
    for (int s = 0; s < QUO_W; s++) begin
      dv_d[s+1] = dv_q[s];
      sh = dv_q[s].dvs << (QUO_W - 1 - s);
      for (int k = 0; k < LANES; k++) begin
        if (dv_q[s].rem[k] >= sh) begin
          dv_d[s+1].rem[k]              = dv_q[s].rem[k] - sh;
          dv_d[s+1].quo[k][QUO_W-1-s]   = 1'b1;
        end
      end
    end
  end

  // ground and hole tests on the finished quotients
  always_comb begin
    div_t                    f;
    logic [QUO_W-1:0]        q [LANES];
    logic signed [EXT_W-1:0] e [3];
    logic signed [IX_W-1:0]  ix, iy, iz;
    logic                    above, far;
    f = dv_q[QUO_W];
    for (int k = 0; k < LANES; k++) begin
      q[k] = f.ovf[k] ? '1 : f.quo[k];
    end
    for (int k = 0; k < 3; k++) begin
      e[k] = f.neg[k] ? -$signed({1'b0, q[k]}) : $signed({1'b0, q[k]});
    end
    ix    = IX_W'(cfg_i.ox) + IX_W'(e[0]);
    iy    = IX_W'(cfg_i.oy) + IX_W'(e[1]);
    iz    = IX_W'(cfg_i.oz) + IX_W'(e[2]);
    above = CMP_W'(f.pz) > (CMP_W'(iz) + CMP_W'(HEIGHT_MARGIN));
    far   = CMP_W'(f.rp) > (CMP_W'(q[LANE_R]) + CMP_W'(cfg_i.tol));
    hole_d = vld_q[BK_STAGES-1] && !above && far;
    hx_d   = sat_crd(ix);
    hy_d   = sat_crd(iy);
    hz_d   = sat_crd(iz);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[BK_STAGES-2:0], head_vld_i};
      out_vld_q <= hole_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i <= SQ_STEPS; i++) sq_q[i] <= sq_d[i];
      m1_q <= m1_d;
      m2_q <= m2_d;
      for (int s = 0; s <= QUO_W; s++) dv_q[s] <= dv_d[s];
      hx_q <= hx_d;
      hy_q <= hy_d;
      hz_q <= hz_d;
      rx_q <= dv_q[QUO_W].px;
      ry_q <= dv_q[QUO_W].py;
      rz_q <= dv_q[QUO_W].pz;
    end
  end

  assign hole_o.valid  = out_vld_q;
  assign hole_o.hole_x = hx_q;
  assign hole_o.hole_y = hy_q;
  assign hole_o.hole_z = hz_q;
  assign hole_o.raw_x  = rx_q;
  assign hole_o.raw_y  = ry_q;
  assign hole_o.raw_z  = rz_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !hole_o.ready) |=> (out_vld_q && $stable(hx_q) && $stable(rz_q)))
    else $error("held result changed");

  a_pop_only_when_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> en)
    else $error("pop while back end stalled");

  a_tail_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && !vld_q[BK_STAGES-1]) |=> !out_vld_q)
    else $error("result without item");

endmodule

>>> rtl/core/lidar_ground_hole_detector.sv
// Top level: configuration registers, front end, job queue, back end.
// Depends on lghd_pkg, lghd_stream_if, lghd_front, lghd_fifo, lghd_back.
//
//   port      dir   kind        payload
//   cfg_*     in    write only  register index, data
//   point_i   in    valid/ready point_x, point_y, point_z
//   hole_o    out   valid/ready hole_x..z, raw_x..z
//
// One point request per cycle sustained while the queue is not full; a hole's
// valid rises once its point has passed 2 front stages, the queue, 22 square
// root stages, 2 multiply stages, 23 divider stages and the output register.
// Reset is asynchronous; it clears all valid state and loads the register defaults.
// A stalled output freezes the back end; the 4-entry queue lets the front
// keep accepting until it fills. Parallel rays never occupy the queue.
`timescale 1ns / 1ps

module lidar_ground_hole_detector import lghd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  lghd_point_if.sink            point_i,
  lghd_hole_if.source           hole_o
);

  cfg_t cfg_q;
  logic push, full, pop, head_vld;
  job_t job, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ox  <= '0;
      cfg_q.oy  <= '0;
      cfg_q.oz  <= '0;
      cfg_q.a   <= '0;
      cfg_q.b   <= '0;
      cfg_q.c   <= NRM_W'(32767);
      cfg_q.d   <= '0;
      cfg_q.tol <= TOL_W'(100);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ORIGIN_X:  cfg_q.ox  <= cfg_wdata_i;
        REG_ORIGIN_Y:  cfg_q.oy  <= cfg_wdata_i;
        REG_ORIGIN_Z:  cfg_q.oz  <= cfg_wdata_i;
        REG_NORMAL_A:  cfg_q.a   <= cfg_wdata_i[NRM_W-1:0];
        REG_NORMAL_B:  cfg_q.b   <= cfg_wdata_i[NRM_W-1:0];
        REG_NORMAL_C:  cfg_q.c   <= cfg_wdata_i[NRM_W-1:0];
        REG_PLANE_OFS: cfg_q.d   <= cfg_wdata_i;
        REG_RANGE_TOL: cfg_q.tol <= cfg_wdata_i[TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lghd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .point_i (point_i),
    .full_i  (full),
    .push_o  (push),
    .job_o   (job)
  );

  lghd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .job_i      (job),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head),
    .head_vld_o (head_vld)
  );

  lghd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .head_i     (head),
    .head_vld_i (head_vld),
    .pop_o      (pop),
    .hole_o     (hole_o)
  );

endmodule

>>> tb/tb_lidar_ground_hole_detector.sv
// Self-checking testbench for the lidar ground hole detector: drives points
// with random idling, predicts holes in exact integer math, checks outputs.
// Depends on lghd_pkg, lghd_stream_if and the detector RTL.
`timescale 1ns / 1ps

module tb_lidar_ground_hole_detector;
  import lghd_pkg::*;

  typedef struct {
    logic signed [CRD_W-1:0] hx, hy, hz, rx, ry, rz;
  } hole_t;

  typedef struct {
    logic signed [CRD_W-1:0] x, y, z;
    bit                      chk;   // typed-in expectation present
    bit                      hole;
    logic signed [CRD_W-1:0] hx, hy, hz;
  } pt_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  lghd_point_if pt_if ();
  lghd_hole_if  hl_if ();

  lidar_ground_hole_detector u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .point_i(pt_if.sink), .hole_o(hl_if.source)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the configuration
  longint org_x, org_y, org_z, nrm_a, nrm_b, nrm_c, pl_d, tol;
  hole_t  hole_q[$];
  int     errors = 0;
  int     n_holes = 0;
  int     n_points = 0;
  bit     hold_off = 1'b0;
  bit     rdy_long = 1'b0;

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint round_div(longint n, longint d);
    longint q;
    q = (2 * absl(n) + absl(d)) / (2 * absl(d));
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [CRD_W-1:0] clamp20(longint v);
    if (v > CRD_MAX) return CRD_W'(CRD_MAX);
    if (v < CRD_MIN) return CRD_W'(CRD_MIN);
    return CRD_W'(v);
  endfunction

  // returns 1 and the hole when the point is flagged
  function automatic bit predict_hole(longint px, longint py, longint pz,
                                      output hole_t h);
    longint dx, dy, dz, den, num, ex, ey, ez, iz, rp, ri;
    dx = px - org_x;
    dy = py - org_y;
    dz = pz - org_z;
    h = '{default: '0};
    den = nrm_a * dx + nrm_b * dy + nrm_c * dz;
    if (den == 0) return 0;
    num = -(nrm_a * org_x + nrm_b * org_y + nrm_c * org_z + pl_d * 32768);
    ex = round_div(num * dx, den);
    ey = round_div(num * dy, den);
    ez = round_div(num * dz, den);
    iz = org_z + ez;
    if (pz > iz + HEIGHT_MARGIN) return 0;
    rp = int_sqrt(dx * dx + dy * dy + dz * dz);
    ri = round_div(rp * absl(num), absl(den));
    if (!(rp > ri + tol)) return 0;
    h.hx = clamp20(org_x + ex);
    h.hy = clamp20(org_y + ey);
    h.hz = clamp20(iz);
    h.rx = CRD_W'(px);
    h.ry = CRD_W'(py);
    h.rz = CRD_W'(pz);
    return 1;
  endfunction

  // leaves the write enable high; set_config drops it after the last write
  task automatic write_reg(reg_idx_e idx, longint val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CFG_DATA_W'(val);
    @(posedge clk_i);
    case (idx)
      REG_ORIGIN_X:  org_x = longint'($signed(CRD_W'(val)));
      REG_ORIGIN_Y:  org_y = longint'($signed(CRD_W'(val)));
      REG_ORIGIN_Z:  org_z = longint'($signed(CRD_W'(val)));
      REG_NORMAL_A:  nrm_a = longint'($signed(NRM_W'(val)));
      REG_NORMAL_B:  nrm_b = longint'($signed(NRM_W'(val)));
      REG_NORMAL_C:  nrm_c = longint'($signed(NRM_W'(val)));
      REG_PLANE_OFS: pl_d  = longint'($signed(CRD_W'(val)));
      REG_RANGE_TOL: tol   = longint'(TOL_W'(val));
      default: ;
    endcase
  endtask

  task automatic set_config(longint ox, oy, oz, a, b, c, d, t);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_NORMAL_A, a);
    write_reg(REG_NORMAL_B, b);
    write_reg(REG_NORMAL_C, c);
    write_reg(REG_PLANE_OFS, d);
    write_reg(REG_RANGE_TOL, t);
    cfg_we_i <= 1'b0;
  endtask

  // wait for the pipeline to drain, including dropped points still in flight
  task automatic drain();
    while (hole_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 55) n = 0;
    else if (r < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n != 0) begin
      pt_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_point(pt_row_t row);
    hole_t h;
    bit    hit;
    pt_if.valid   <= 1'b1;
    pt_if.point_x <= row.x;
    pt_if.point_y <= row.y;
    pt_if.point_z <= row.z;
    do @(posedge clk_i); while (!pt_if.ready);
    hit = predict_hole(row.x, row.y, row.z, h);
    if (row.chk && (hit != row.hole ||
        (hit && (h.hx != row.hx || h.hy != row.hy || h.hz != row.hz)))) begin
      $display("%0t directed row (%0d,%0d,%0d): table hole=%0b pred hole=%0b",
               $time, row.x, row.y, row.z, row.hole, hit);
      errors++;
    end
    if (hit) hole_q.insert(hole_q.size(), h);
    n_points++;
    if ($urandom_range(0, 1) == 0) idle_gap();
  endtask

  function automatic logic signed [CRD_W-1:0] rnd_crd();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return CRD_W'(CRD_MAX);
    if (r == 1) return CRD_W'(CRD_MIN);
    if (r < 5) return CRD_W'($urandom);
    return CRD_W'($signed(14'($urandom)));
  endfunction

  // mostly points below a ground plane near z = 0 so holes are common
  function automatic pt_row_t rnd_point();
    pt_row_t p;
    p = '{default: '0};
    p.x = rnd_crd();
    p.y = rnd_crd();
    if ($urandom_range(0, 3) != 0) p.z = -CRD_W'($urandom_range(1, 30000));
    else p.z = rnd_crd();
    return p;
  endfunction

  // output side: random stalls, one long hold-off, checking
  always @(posedge clk_i) begin
    if (hl_if.valid && hl_if.ready) begin
      if (hole_q.size() == 0) begin
        $display("%0t unexpected hole (%0d,%0d,%0d)", $time,
                 hl_if.hole_x, hl_if.hole_y, hl_if.hole_z);
        errors++;
      end else begin
        hole_t e;
        e = hole_q.pop_front();
        n_holes++;
        if (hl_if.hole_x !== e.hx || hl_if.hole_y !== e.hy ||
            hl_if.hole_z !== e.hz || hl_if.raw_x !== e.rx ||
            hl_if.raw_y !== e.ry || hl_if.raw_z !== e.rz) begin
          $display("%0t hole mismatch: exp (%0d,%0d,%0d | %0d,%0d,%0d)", $time,
                   e.hx, e.hy, e.hz, e.rx, e.ry, e.rz);
          $display("%0t                got (%0d,%0d,%0d | %0d,%0d,%0d)", $time,
                   hl_if.hole_x, hl_if.hole_y, hl_if.hole_z,
                   hl_if.raw_x, hl_if.raw_y, hl_if.raw_z);
          errors++;
        end
      end
    end
  end

  initial begin
    hl_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        hl_if.ready <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end else if (rdy_long) begin
        hl_if.ready <= 1'b1;
      end else begin
        case ($urandom_range(0, 19))
          0: hl_if.ready <= 1'b0;
          1: begin
            hl_if.ready <= 1'b0;
            repeat ($urandom_range(5, 30)) @(posedge clk_i);
          end
          default: hl_if.ready <= 1'b1;
        endcase
      end
    end
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // directed points for the reset config (ground z = 0, origin at 0, tol 100)
  pt_row_t dir_tab[] = '{
    '{x: 0, y: 0, z: 0, chk: 1, hole: 0, hx: 0, hy: 0, hz: 0},       // parallel
    '{x: 1000, y: 0, z: 0, chk: 1, hole: 0, hx: 0, hy: 0, hz: 0},    // parallel
    '{x: 0, y: 0, z: -1000, chk: 1, hole: 1, hx: 0, hy: 0, hz: 0},
    '{x: 0, y: 0, z: 1000, chk: 1, hole: 0, hx: 0, hy: 0, hz: 0},    // above
    '{x: 0, y: 0, z: -100, chk: 1, hole: 0, hx: 0, hy: 0, hz: 0},    // within tol
    '{x: 524287, y: 524287, z: -524288, chk: 1, hole: 1, hx: 0, hy: 0, hz: 0},
    '{x: -524288, y: -524288, z: 524287, chk: 1, hole: 0, hx: 0, hy: 0, hz: 0},
    '{x: -524288, y: 524287, z: -1, chk: 0, hole: 0, hx: 0, hy: 0, hz: 0},
    '{x: 5, y: -7, z: -524288, chk: 0, hole: 0, hx: 0, hy: 0, hz: 0}
  };

  // tilted plane, origin above ground: above-ground and saturation cases
  pt_row_t tilt_tab[] = '{
    '{x: 3000, y: 0, z: 0, chk: 0, hole: 0, hx: 0, hy: 0, hz: 0},
    '{x: 3000, y: 0, z: 1900, chk: 0, hole: 0, hx: 0, hy: 0, hz: 0},
    '{x: 524287, y: 524287, z: 1999, chk: 0, hole: 0, hx: 0, hy: 0, hz: 0},
    '{x: 524287, y: -524288, z: 1999, chk: 0, hole: 0, hx: 0, hy: 0, hz: 0},
    '{x: -524288, y: 0, z: -524288, chk: 0, hole: 0, hx: 0, hy: 0, hz: 0},
    '{x: 10, y: 10, z: -5000, chk: 0, hole: 0, hx: 0, hy: 0, hz: 0},
    '{x: 100000, y: 0, z: 1500, chk: 0, hole: 0, hx: 0, hy: 0, hz: 0},
    '{x: 0, y: 0, z: 2000, chk: 0, hole: 0, hx: 0, hy: 0, hz: 0}
  };

  initial begin
    org_x = 0; org_y = 0; org_z = 0;
    nrm_a = 0; nrm_b = 0; nrm_c = 32767; pl_d = 0; tol = 100;
    pt_if.valid <= 1'b0;
    pt_if.point_x <= '0;
    pt_if.point_y <= '0;
    pt_if.point_z <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_point(dir_tab[i]);
    pt_if.valid <= 1'b0;
    drain();

    set_config(0, 0, 2000, 3000, -2000, 32000, 0, 0);
    foreach (tilt_tab[i]) send_point(tilt_tab[i]);
    pt_if.valid <= 1'b0;
    drain();

    // extreme register values
    set_config(CRD_MAX, CRD_MIN, CRD_MIN, -32768, 32767, -32768, CRD_MAX, 65535);
    for (int i = 0; i < 40; i++) send_point(rnd_point());
    pt_if.valid <= 1'b0;
    drain();
    set_config(CRD_MIN, CRD_MAX, CRD_MAX, 32767, -32768, 32767, CRD_MIN, 0);
    for (int i = 0; i < 40; i++) send_point(rnd_point());
    pt_if.valid <= 1'b0;
    drain();

    // back-pressure: output held off while points keep coming, until the
    // pipeline and queue fill and the input stalls
    set_config(0, 0, 1500, 0, 0, 32767, 0, 50);
    hold_off = 1'b1;
    rdy_long = 1'b0;
    for (int i = 0; i < 120; i++) begin
      pt_row_t p;
      p = rnd_point();
      p.z = -CRD_W'($urandom_range(100, 9000));
      pt_if.valid <= 1'b1;
      pt_if.point_x <= p.x;
      pt_if.point_y <= p.y;
      pt_if.point_z <= p.z;
      do @(posedge clk_i); while (!pt_if.ready);
      begin
        hole_t h;
        if (predict_hole(p.x, p.y, p.z, h)) hole_q.insert(hole_q.size(), h);
      end
      n_points++;
    end
    pt_if.valid <= 1'b0;
    drain();

    // random phases with varied ground planes
    for (int ph = 0; ph < 8; ph++) begin
      set_config($signed(12'($urandom)), $signed(12'($urandom)),
                 $urandom_range(0, 3000),
                 $signed(12'($urandom)), $signed(12'($urandom)),
                 $urandom_range(20000, 32767),
                 $signed(10'($urandom)), $urandom_range(0, 400));
      rdy_long = (ph % 3 == 2);
      for (int i = 0; i < 50; i++) send_point(rnd_point());
      pt_if.valid <= 1'b0;
      drain();
    end

    $display("covered %0d points, %0d holes checked, 12 register settings",
             n_points, n_holes);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/lghd_pkg.sv
rtl/core/lghd_stream_if.sv
rtl/core/lghd_front.sv
rtl/core/lghd_fifo.sv
rtl/core/lghd_back.sv
rtl/core/lidar_ground_hole_detector.sv
tb/tb_lidar_ground_hole_detector.sv
